// File: sv/utd_pkg.sv
// Shared types, constants and controller codes for the unitary trace distance block.
package utd_pkg;

	// Field and datapath widths
	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = 2 * SAMPLE_W;
	localparam int TERM_W   = PROD_W + 1;
	localparam int ACC_W    = 40;
	localparam int MAG_SHIFT = 8;
	localparam int MAG_W    = ACC_W - MAG_SHIFT;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int ROOT_W   = SQ_W / 2;
	localparam int ROWS_W   = 5;
	localparam int DIST_W   = 16;
	localparam int RAD_W    = 21;
	localparam int RAD_SHIFT = 10;

	// Fixed-point constants
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [ROOT_W-1:0] ONE_Q20 = ROOT_W'(1) << 20;
	localparam logic [SQ_W-1:0] SQRT_BIT_INIT = SQ_W'(1) << (SQ_W - 2);
	localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(2);

	// One input transaction
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] pivot_real;
		logic signed [SAMPLE_W-1:0] pivot_imag;
		logic signed [SAMPLE_W-1:0] gate_real;
		logic signed [SAMPLE_W-1:0] gate_imag;
		logic                       last_element;
	} utd_item_t;

	// One result transaction
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              clamped;
	} utd_result_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_ACC,
		ST_FLUSH,
		ST_SQUARE,
		ST_SUM,
		ST_MAG_GO,
		ST_MAG_WAIT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_RAD,
		ST_DIST_GO,
		ST_DIST_WAIT,
		ST_OUT
	} utd_state_t;

	// Controller to datapath
	typedef struct packed {
		logic take_item;
		logic acc_clear;
		logic square;
		logic sum;
		logic sqrt_start;
		logic sqrt_rad;
		logic div_start;
		logic set_clamp;
		logic rad_load;
		logic out_load;
	} utd_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sqrt_done;
		logic div_done;
		logic rows_zero;
		logic over;
		logic out_free;
	} utd_stat_t;

endpackage

// File: sv/utd_stream_if.sv
// Valid/ready channel carrying one payload per transaction.
interface utd_stream_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/unitary_trace_distance.sv
// Top level of the unitary trace distance block.
//
//   channel  dir  payload                                           transaction
//   item     in   pivot_real/imag, gate_real/imag (Q2.14), last     one matrix element
//   result   out  distance (Q1.15), clamped                        one per last element
//   cfg      in   matrix_rows (5 bits)                              register write
//
// Elements that are not last are taken one per cycle (complex MAC, two stages).
// The last element holds item.ready low through flush, square and sum, root start plus a
// 32-step root, divide start plus 32 steps by the row count, radicand, second root and
// the result load. A row count of zero skips to the load after the first root; a
// quotient above one skips the second root. The load waits while an untaken result still
// sits in the result register, so a new run cannot start behind a waiting result.
// Reset clears the accumulators and sets the row count to 2; cfg is always ready.
module unitary_trace_distance #(
	parameter int MAX_ROWS = 16
) (
	input logic          clk,
	input logic          arst_n,
	utd_stream_if.sink   item,
	utd_stream_if.source result,
	utd_stream_if.sink   cfg
);

	utd_pkg::utd_cmd_t  cmd;
	utd_pkg::utd_stat_t stat;
	logic               item_fire;
	logic               cfg_fire;

	// Handshakes
	assign item.ready = cmd.take_item;
	assign cfg.ready  = 1'b1;
	assign item_fire  = item.valid && item.ready;
	assign cfg_fire   = cfg.valid && cfg.ready;

	utd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_fire (item_fire),
		.item_last (item.data.last_element),
		.stat      (stat),
		.cmd       (cmd)
	);

	utd_dp #(
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_fire (item_fire),
		.item_data (item.data),
		.cfg_fire  (cfg_fire),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.stat      (stat),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.res_data  (result.data)
	);

endmodule

// File: sv/utd_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
module utd_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [utd_pkg::SQ_W-1:0]    operand,
	output logic                        done,
	output logic [utd_pkg::ROOT_W-1:0]  root
);

	logic [utd_pkg::SQ_W-1:0] x_q;
	logic [utd_pkg::SQ_W-1:0] res_q;
	logic [utd_pkg::SQ_W-1:0] bit_q;
	logic [utd_pkg::SQ_W-1:0] trial;
	logic                     ge;
	logic                     busy_q;
	logic                     done_q;

	// Trial subtraction of the current step
	assign trial = res_q + bit_q;
	assign ge    = (x_q >= trial);

	// Busy and done flags; the last step is the one with the lowest bit set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Remainder, partial root and step bit
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= operand;
			res_q <= '0;
			bit_q <= utd_pkg::SQRT_BIT_INIT;
		end else if (busy_q) begin
			if (ge) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[utd_pkg::ROOT_W-1:0];

endmodule

// File: sv/utd_div.sv
// Restoring divider, one quotient bit per cycle, narrow divisor.
module utd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [utd_pkg::ROOT_W-1:0]  dividend,
	input  logic [utd_pkg::ROWS_W-1:0]  divisor,
	output logic                        done,
	output logic [utd_pkg::ROOT_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(utd_pkg::ROOT_W);

	logic [utd_pkg::ROWS_W-1:0] rem_q;
	logic [utd_pkg::ROWS_W-1:0] dvs_q;
	logic [utd_pkg::ROOT_W-1:0] quo_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [utd_pkg::ROWS_W:0]   trial;
	logic [utd_pkg::ROWS_W:0]   diff;
	logic                       ge;

	// Shift in the next dividend bit and try the divisor
	assign trial = {rem_q, quo_q[utd_pkg::ROOT_W-1]};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	// Step counter and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(utd_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[utd_pkg::ROWS_W-1:0] : trial[utd_pkg::ROWS_W-1:0];
			quo_q <= {quo_q[utd_pkg::ROOT_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: sv/utd_dp.sv
// Datapath: complex MAC, magnitude, normalize and distance root, result register.
module utd_dp #(
	parameter int MAX_ROWS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_fire,
	input  utd_pkg::utd_item_t           item_data,
	input  logic                         cfg_fire,
	input  logic [utd_pkg::ROWS_W-1:0]   cfg_data,
	input  utd_pkg::utd_cmd_t            cmd,
	output utd_pkg::utd_stat_t           stat,
	output logic                         res_valid,
	input  logic                         res_ready,
	output utd_pkg::utd_result_t         res_data
);

	// Product stage
	logic signed [utd_pkg::PROD_W-1:0] p_rr, p_ii, p_ir, p_ri;
	logic signed [utd_pkg::TERM_W-1:0] term_re_s1, term_im_s1;
	logic                              valid_s1;

	// Accumulators
	logic signed [utd_pkg::ACC_W-1:0]  acc_re_q, acc_im_q;
	logic signed [utd_pkg::ACC_W:0]    sum_re, sum_im;

	// Magnitude path
	logic [utd_pkg::ACC_W-1:0]         abs_re, abs_im;
	logic [utd_pkg::MAG_W-1:0]         mr, mi;
	logic [utd_pkg::SQ_W-1:0]          sq_re, sq_im;
	logic [utd_pkg::SQ_W-1:0]          sq_re_q, sq_im_q, sq_sum_q;

	// Normalize and result
	logic [utd_pkg::ROWS_W-1:0]        rows_q, rows_eff;
	logic [utd_pkg::RAD_W-1:0]         rad_q;
	logic                              clamp_q;
	logic [utd_pkg::SQ_W-1:0]          sqrt_in;
	logic [utd_pkg::ROOT_W-1:0]        root;
	logic [utd_pkg::ROOT_W-1:0]        quot;
	logic                              sqrt_done, div_done;
	logic                              res_valid_q;
	utd_pkg::utd_result_t              res_q;

	// Row count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= utd_pkg::ROWS_RESET;
		end else if (cfg_fire) begin
			rows_q <= cfg_data;
		end
	end

	assign rows_eff = (int'(rows_q) > MAX_ROWS) ? utd_pkg::ROWS_W'(MAX_ROWS) : rows_q;

	// Four partial products of pivot * conj(gate)
	assign p_rr = item_data.pivot_real * item_data.gate_real;
	assign p_ii = item_data.pivot_imag * item_data.gate_imag;
	assign p_ir = item_data.pivot_imag * item_data.gate_real;
	assign p_ri = item_data.pivot_real * item_data.gate_imag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= item_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			term_re_s1 <= {p_rr[utd_pkg::PROD_W-1], p_rr} + {p_ii[utd_pkg::PROD_W-1], p_ii};
			term_im_s1 <= {p_ir[utd_pkg::PROD_W-1], p_ir} - {p_ri[utd_pkg::PROD_W-1], p_ri};
		end
	end

	// Saturating accumulation
	assign sum_re = {acc_re_q[utd_pkg::ACC_W-1], acc_re_q}
		+ {{(utd_pkg::ACC_W + 1 - utd_pkg::TERM_W){term_re_s1[utd_pkg::TERM_W-1]}}, term_re_s1};
	assign sum_im = {acc_im_q[utd_pkg::ACC_W-1], acc_im_q}
		+ {{(utd_pkg::ACC_W + 1 - utd_pkg::TERM_W){term_im_s1[utd_pkg::TERM_W-1]}}, term_im_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (cmd.acc_clear) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (valid_s1) begin
			if (sum_re[utd_pkg::ACC_W] != sum_re[utd_pkg::ACC_W-1]) begin
				acc_re_q <= sum_re[utd_pkg::ACC_W] ? utd_pkg::ACC_MIN : utd_pkg::ACC_MAX;
			end else begin
				acc_re_q <= sum_re[utd_pkg::ACC_W-1:0];
			end
			if (sum_im[utd_pkg::ACC_W] != sum_im[utd_pkg::ACC_W-1]) begin
				acc_im_q <= sum_im[utd_pkg::ACC_W] ? utd_pkg::ACC_MIN : utd_pkg::ACC_MAX;
			end else begin
				acc_im_q <= sum_im[utd_pkg::ACC_W-1:0];
			end
		end
	end

	// Magnitudes truncated to Q20, then squared
	assign abs_re = acc_re_q[utd_pkg::ACC_W-1] ? (~acc_re_q + 1'b1) : acc_re_q;
	assign abs_im = acc_im_q[utd_pkg::ACC_W-1] ? (~acc_im_q + 1'b1) : acc_im_q;
	assign mr     = abs_re[utd_pkg::ACC_W-1:utd_pkg::MAG_SHIFT];
	assign mi     = abs_im[utd_pkg::ACC_W-1:utd_pkg::MAG_SHIFT];
	assign sq_re  = mr * mr;
	assign sq_im  = mi * mi;

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sq_re_q <= sq_re;
			sq_im_q <= sq_im;
		end
		if (cmd.sum) begin
			sq_sum_q <= sq_re_q + sq_im_q;
		end
	end

	// Shared square root: |T| first, then the distance
	assign sqrt_in = cmd.sqrt_rad
		? {{(utd_pkg::SQ_W - utd_pkg::RAD_W - utd_pkg::RAD_SHIFT){1'b0}}, rad_q,
		   {utd_pkg::RAD_SHIFT{1'b0}}}
		: sq_sum_q;

	utd_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.sqrt_start),
		.operand (sqrt_in),
		.done    (sqrt_done),
		.root    (root)
	);

	utd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (root),
		.divisor  (rows_eff),
		.done     (div_done),
		.quotient (quot)
	);

	// Radicand and clamp flag
	always_ff @(posedge clk) begin
		if (cmd.acc_clear) begin
			clamp_q <= 1'b0;
		end else if (cmd.set_clamp) begin
			clamp_q <= 1'b1;
		end else if (cmd.rad_load) begin
			clamp_q <= stat.over;
		end
		if (cmd.rad_load) begin
			rad_q <= utd_pkg::ONE_Q20[utd_pkg::RAD_W-1:0] - quot[utd_pkg::RAD_W-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.distance <= clamp_q ? '0 : root[utd_pkg::DIST_W-1:0];
			res_q.clamped  <= clamp_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Status to the controller
	assign stat.sqrt_done = sqrt_done;
	assign stat.div_done  = div_done;
	assign stat.rows_zero = (rows_q == '0);
	assign stat.over      = (quot > utd_pkg::ONE_Q20);
	assign stat.out_free  = !res_valid_q || res_ready;

endmodule

// File: sv/utd_ctrl.sv
// Controller: sequences accumulation and the finishing steps of one matrix pair.
module utd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_fire,
	input  logic                 item_last,
	input  utd_pkg::utd_stat_t   stat,
	output utd_pkg::utd_cmd_t    cmd
);

	utd_pkg::utd_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= utd_pkg::ST_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			utd_pkg::ST_ACC: begin
				if (item_fire && item_last) state_d = utd_pkg::ST_FLUSH;
			end
			utd_pkg::ST_FLUSH:  state_d = utd_pkg::ST_SQUARE;
			utd_pkg::ST_SQUARE: state_d = utd_pkg::ST_SUM;
			utd_pkg::ST_SUM:    state_d = utd_pkg::ST_MAG_GO;
			utd_pkg::ST_MAG_GO: state_d = utd_pkg::ST_MAG_WAIT;
			utd_pkg::ST_MAG_WAIT: begin
				if (stat.sqrt_done) begin
					state_d = stat.rows_zero ? utd_pkg::ST_OUT : utd_pkg::ST_DIV_GO;
				end
			end
			utd_pkg::ST_DIV_GO: state_d = utd_pkg::ST_DIV_WAIT;
			utd_pkg::ST_DIV_WAIT: begin
				if (stat.div_done) state_d = utd_pkg::ST_RAD;
			end
			utd_pkg::ST_RAD: begin
				state_d = stat.over ? utd_pkg::ST_OUT : utd_pkg::ST_DIST_GO;
			end
			utd_pkg::ST_DIST_GO: state_d = utd_pkg::ST_DIST_WAIT;
			utd_pkg::ST_DIST_WAIT: begin
				if (stat.sqrt_done) state_d = utd_pkg::ST_OUT;
			end
			utd_pkg::ST_OUT: begin
				if (stat.out_free) state_d = utd_pkg::ST_ACC;
			end
			default: state_d = utd_pkg::ST_ACC;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		case (state_q)
			utd_pkg::ST_ACC:    cmd.take_item = 1'b1;
			utd_pkg::ST_FLUSH:  ;
			utd_pkg::ST_SQUARE: begin
				cmd.square    = 1'b1;
				cmd.acc_clear = 1'b1;
			end
			utd_pkg::ST_SUM:    cmd.sum = 1'b1;
			utd_pkg::ST_MAG_GO: cmd.sqrt_start = 1'b1;
			utd_pkg::ST_MAG_WAIT: begin
				cmd.set_clamp = stat.sqrt_done && stat.rows_zero;
			end
			utd_pkg::ST_DIV_GO: cmd.div_start = 1'b1;
			utd_pkg::ST_DIV_WAIT: ;
			utd_pkg::ST_RAD:    cmd.rad_load = 1'b1;
			utd_pkg::ST_DIST_GO: begin
				cmd.sqrt_start = 1'b1;
				cmd.sqrt_rad   = 1'b1;
			end
			utd_pkg::ST_DIST_WAIT: ;
			utd_pkg::ST_OUT:    cmd.out_load = stat.out_free;
			default: ;
		endcase
	end

endmodule
